FILE: hw/rtl/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared sizes, codes and types of the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  // Sizes
  localparam int PAGE_BITS   = 12;
  localparam int ADDR_BITS   = 40;
  localparam int STACK_DEPTH = 16384;

  localparam int PAGE_W    = ADDR_BITS - PAGE_BITS;      // page number width
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);    // holds 0..STACK_DEPTH
  localparam int IDX_W     = $clog2(STACK_DEPTH);        // stack entry index
  localparam int CFG_IDX_W = 2;

  // Request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAM_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_STOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 2'd2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [1:0]           kind_t;
  typedef logic [1:0]           status_t;

  // Address check and init bounds, handed from the checker to the top level
  typedef struct packed {
    logic  free_ok;
    logic  run_nonempty;
    page_t run_floor;
    page_t run_next;
  } chk_t;

endpackage

FILE: hw/rtl/fpsa_ram.sv
// ----------------------------------------------------------------------------
// fpsa_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/fpsa_chk.sv
// ----------------------------------------------------------------------------
// fpsa_chk
// Free address check and init run bounds from the window registers.
// ----------------------------------------------------------------------------
module fpsa_chk (
  input  fpsa_pkg::addr_t ram_base,
  input  fpsa_pkg::addr_t ram_stop,
  input  fpsa_pkg::addr_t kernel_end,
  input  fpsa_pkg::addr_t address,
  output fpsa_pkg::chk_t  chk
);
  import fpsa_pkg::*;

  localparam addr_t OFF_MASK = {{PAGE_W{1'b0}}, {PAGE_BITS{1'b1}}};

  logic [ADDR_BITS:0] ke_sum;
  logic [ADDR_BITS:0] rb_sum;
  logic [PAGE_W:0]    ke_up;
  logic [PAGE_W:0]    rb_up;
  logic [PAGE_W:0]    lo;
  page_t              hi;

  // Round both lower bounds up to a page; may reach one past the top page
  assign ke_sum = {1'b0, kernel_end} + {1'b0, OFF_MASK};
  assign rb_sum = {1'b0, ram_base} + {1'b0, OFF_MASK};
  assign ke_up  = ke_sum[ADDR_BITS:PAGE_BITS];
  assign rb_up  = rb_sum[ADDR_BITS:PAGE_BITS];
  assign lo     = (rb_up > ke_up) ? rb_up : ke_up;
  assign hi     = ram_stop[ADDR_BITS-1:PAGE_BITS];

  always_comb begin
    // Free check: aligned, not below either lower bound, below the top
    chk.free_ok = ((address & OFF_MASK) == '0) && (address >= kernel_end) &&
                  (address >= ram_base) && (address < ram_stop);

    // Run covers [lo, hi) when not empty
    if (lo < {1'b0, hi}) begin
      chk.run_nonempty = 1'b1;
      chk.run_floor    = lo[PAGE_W-1:0];
      chk.run_next     = hi - page_t'(1);
    end else begin
      chk.run_nonempty = 1'b0;
      chk.run_floor    = '0;
      chk.run_next     = '0;
    end
  end

endmodule

FILE: hw/rtl/free_page_stack_allocator.sv
// ----------------------------------------------------------------------------
// free_page_stack_allocator
// LIFO free page allocator: a stack of freed pages in RAM over a descending
// run of never-allocated pages.
//
// Usage:
//   Input beat: in_kind (alloc, free, init) and in_address (page to free).
//   Each input beat yields exactly one output beat: out_page_address (zero
//   unless an alloc succeeds) and out_status (ok, out of memory, bad
//   address, stack full). Window registers ram_base, ram_stop and
//   kernel_end are written through cfg_we/cfg_index/cfg_wdata; the user
//   must write them only while idle, which the block does not enforce.
//   The result is registered; an alloc served from the freed stack passes
//   through the stack RAM read register and then the output register, and
//   in_ready stays low until that pop is done. A free writes the stack top
//   in its accept cycle, so any later alloc reads it back with no
//   forwarding.
//   Reset empties the stack and the run and clears the window registers;
//   no clearing pass is needed. An init request rebuilds the run.
//   When the receiver stalls, the result waits in the output register;
//   in_ready drops until that register can take the next result.
// ----------------------------------------------------------------------------
module free_page_stack_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fpsa_pkg::kind_t                     in_kind,
  input  fpsa_pkg::addr_t                     in_address,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output fpsa_pkg::addr_t                     out_page_address,
  output fpsa_pkg::status_t                   out_status,
  // configuration port
  input  logic                                cfg_we,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  fpsa_pkg::addr_t                     cfg_wdata
);
  import fpsa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  // Window registers
  addr_t ram_base_r, ram_stop_r, kernel_end_r;

  // Allocator state
  logic  state_r, state_nxt;
  cnt_t  count_r, count_nxt;
  page_t run_next_r, run_next_nxt;
  page_t run_floor_r, run_floor_nxt;
  logic  run_nonempty_r, run_nonempty_nxt;

  // Output register
  logic    out_valid_r, out_valid_nxt;
  addr_t   out_page_r, out_page_nxt;
  status_t out_status_r, out_status_nxt;
  logic    out_load;

  // Stack RAM port signals
  logic             st_we, st_re;
  logic [IDX_W-1:0] st_waddr, st_raddr;
  page_t            st_wdata, st_rdata;
  cnt_t             count_dec;

  chk_t  chk;
  logic  out_free;
  logic  acc;

  fpsa_chk u_chk (
    .ram_base   (ram_base_r),
    .ram_stop   (ram_stop_r),
    .kernel_end (kernel_end_r),
    .address    (in_address),
    .chk        (chk)
  );

  fpsa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Handshake; no beat is taken while reset is held
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = rst_n && (state_r == S_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign count_dec = count_r - cnt_t'(1);

  assign out_valid        = out_valid_r;
  assign out_page_address = out_page_r;
  assign out_status       = out_status_r;

  // Stack addresses: push at the count, pop below it
  assign st_waddr = count_r[IDX_W-1:0];
  assign st_raddr = count_dec[IDX_W-1:0];
  assign st_wdata = in_address[ADDR_BITS-1:PAGE_BITS];

  // Request decode and state update
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    run_next_nxt     = run_next_r;
    run_floor_nxt    = run_floor_r;
    run_nonempty_nxt = run_nonempty_r;
    out_load         = 1'b0;
    out_page_nxt     = '0;
    out_status_nxt   = ST_OK;
    st_we            = 1'b0;
    st_re            = 1'b0;

    if (state_r == S_POP) begin
      // stack top has arrived from the RAM
      if (out_free) begin
        out_load     = 1'b1;
        out_page_nxt = {st_rdata, {PAGE_BITS{1'b0}}};
        state_nxt    = S_IDLE;
      end
    end else if (acc) begin
      case (in_kind)
        KIND_ALLOC: begin
          if (count_r != '0) begin
            st_re     = 1'b1;
            count_nxt = count_dec;
            state_nxt = S_POP;
          end else if (run_nonempty_r) begin
            out_load     = 1'b1;
            out_page_nxt = {run_next_r, {PAGE_BITS{1'b0}}};
            if (run_next_r <= run_floor_r) begin
              run_nonempty_nxt = 1'b0;
            end else begin
              run_next_nxt = run_next_r - page_t'(1);
            end
          end else begin
            out_load       = 1'b1;
            out_status_nxt = ST_OOM;
          end
        end
        KIND_FREE: begin
          out_load = 1'b1;
          if (!chk.free_ok) begin
            out_status_nxt = ST_BAD;
          end else if (count_r >= cnt_t'(STACK_DEPTH)) begin
            out_status_nxt = ST_FULL;
          end else begin
            st_we     = 1'b1;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        KIND_INIT: begin
          out_load         = 1'b1;
          count_nxt        = '0;
          run_nonempty_nxt = chk.run_nonempty;
          run_floor_nxt    = chk.run_floor;
          run_next_nxt     = chk.run_next;
        end
        default: begin
          // unused kind: no effect, plain ok
          out_load = 1'b1;
        end
      endcase
    end

    // output valid tracking
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      run_next_r     <= '0;
      run_floor_r    <= '0;
      run_nonempty_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      run_next_r     <= run_next_nxt;
      run_floor_r    <= run_floor_nxt;
      run_nonempty_r <= run_nonempty_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_page_r   <= out_page_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r   <= '0;
      ram_stop_r   <= '0;
      kernel_end_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAM_BASE:   ram_base_r   <= cfg_wdata;
        REG_RAM_STOP:   ram_stop_r   <= cfg_wdata;
        REG_KERNEL_END: kernel_end_r <= cfg_wdata;
        default: begin
          // no register at this index
        end
      endcase
    end
  end

endmodule

FILE: test/fpsa_page_pool_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpsa_page_pool_pkg
// Scoreboard for the free page stack allocator bench. It holds a page pool
// model that predicts the reply to each accepted request and checks the
// block's replies against those predictions in order.
// ----------------------------------------------------------------------------
package fpsa_page_pool_pkg;
  import fpsa_pkg::*;

  typedef struct packed {
    addr_t   page_address;
    status_t status;
  } reply_t;

  class page_pool_model;
    // Window registers as last written
    addr_t  ram_base;
    addr_t  ram_stop;
    addr_t  kernel_end;
    // Freed pages sit on top of a descending run of pages never handed out
    page_t  freed_pages [STACK_DEPTH];
    int     freed_count;
    page_t  run_top;
    page_t  run_floor;
    bit     run_live;
    reply_t pending_replies [$];
    // Tallies for the end of run summary
    int     mismatches;
    int     requests;
    int     granted;
    int     out_of_memory;
    int     rejected;
    int     overflowed;
    int     rebuilds;

    function new();
      ram_base      = '0;
      ram_stop      = '0;
      kernel_end    = '0;
      freed_count   = 0;
      run_top       = '0;
      run_floor     = '0;
      run_live      = 1'b0;
      mismatches    = 0;
      requests      = 0;
      granted       = 0;
      out_of_memory = 0;
      rejected      = 0;
      overflowed    = 0;
      rebuilds      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, addr_t value);
      case (index)
        REG_RAM_BASE:   ram_base = value;
        REG_RAM_STOP:   ram_stop = value;
        REG_KERNEL_END: kernel_end = value;
        default: ;
      endcase
    endfunction

    // Empty the list and rebuild the run from the rounded-up lower bound
    function void rebuild_run();
      logic [ADDR_BITS:0] round_up;
      logic [ADDR_BITS:0] low_page;
      logic [ADDR_BITS:0] base_page;
      logic [ADDR_BITS:0] top_page;
      round_up = '0;
      round_up[PAGE_BITS-1:0] = '1;
      low_page  = ({1'b0, kernel_end} + round_up) >> PAGE_BITS;
      base_page = ({1'b0, ram_base} + round_up) >> PAGE_BITS;
      top_page  = {1'b0, ram_stop} >> PAGE_BITS;
      if (base_page > low_page) low_page = base_page;
      freed_count = 0;
      if (low_page < top_page) begin
        run_floor = low_page[PAGE_W-1:0];
        run_top   = top_page[PAGE_W-1:0] - 1'b1;
        run_live  = 1'b1;
      end else begin
        run_floor = '0;
        run_top   = '0;
        run_live  = 1'b0;
      end
    endfunction

    // Predict the reply to one accepted request beat
    function void accept_request(kind_t kind, addr_t address);
      reply_t reply;
      reply.page_address = '0;
      reply.status       = ST_OK;
      requests++;
      case (kind)
        KIND_ALLOC: begin
          if (freed_count > 0) begin
            freed_count--;
            reply.page_address = addr_t'(freed_pages[freed_count]) << PAGE_BITS;
          end else if (run_live) begin
            reply.page_address = addr_t'(run_top) << PAGE_BITS;
            if (run_top <= run_floor) run_live = 1'b0;
            else run_top = run_top - 1'b1;
          end else begin
            reply.status = ST_OOM;
          end
        end
        KIND_FREE: begin
          if (address[PAGE_BITS-1:0] != '0 || address < kernel_end ||
              address < ram_base || address >= ram_stop) begin
            reply.status = ST_BAD;
          end else if (freed_count >= STACK_DEPTH) begin
            reply.status = ST_FULL;
          end else begin
            freed_pages[freed_count] = address[ADDR_BITS-1:PAGE_BITS];
            freed_count++;
          end
        end
        KIND_INIT: begin
          rebuild_run();
          rebuilds++;
        end
        default: ;
      endcase
      case (reply.status)
        ST_OOM:  out_of_memory++;
        ST_BAD:  rejected++;
        ST_FULL: overflowed++;
        default: if (kind == KIND_ALLOC) granted++;
      endcase
      pending_replies.push_back(reply);
    endfunction

    task report_mismatch(string field, addr_t got, addr_t want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %h, predicted %h", $time, field, got, want);
    endtask

    // Compare one reply beat with the oldest prediction
    task check_reply(addr_t page_address, status_t status);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("unrequested reply", page_address, '0);
        return;
      end
      want = pending_replies.pop_front();
      if (page_address !== want.page_address)
        report_mismatch("page_address", page_address, want.page_address);
      if (status !== want.status)
        report_mismatch("status", addr_t'(status), addr_t'(want.status));
    endtask
  endclass

endpackage

FILE: test/tb_free_page_stack_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_free_page_stack_allocator
// Self-checking bench for the free page stack allocator. Directed requests
// hit the address checks, window rounding and extreme windows; random
// phases mix allocs, frees, rebuilds and noise over random windows with
// random idling on both sides and one long result stall; a final phase
// pushes a burst of frees back to back and pops them and more.
// ----------------------------------------------------------------------------
module tb_free_page_stack_allocator;
  import fpsa_pkg::*;
  import fpsa_page_pool_pkg::*;

  localparam int    CYCLE_LIMIT   = 1_500_000;
  localparam int    HOLD_CYCLES   = 400;
  localparam int    RANDOM_PHASES = 10;
  localparam int    PHASE_ITEMS   = 90;
  localparam int    BURST_ITEMS   = 40;
  localparam kind_t KIND_RESERVED = 2'd3;
  localparam addr_t ADDR_ONES     = '1;
  localparam addr_t OFFSET_MASK   = addr_t'((64'd1 << PAGE_BITS) - 1);

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  kind_t                in_kind;
  addr_t                in_address;
  logic                 out_valid;
  logic                 out_ready;
  addr_t                out_page_address;
  status_t              out_status;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  addr_t                cfg_wdata;

  page_pool_model pool;
  bit             idle_on;
  int             hold_len;
  int             cycle_count;
  int             window_count;
  addr_t          win_base;
  addr_t          win_stop;
  addr_t          win_kend;
  addr_t          granted_pages [$];

  free_page_stack_allocator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_page_address (out_page_address),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** free_page_stack_allocator: FAILED **");
    $finish;
  end

  function automatic addr_t rand_addr();
    logic [63:0] bits64;
    bits64 = {$urandom(), $urandom()};
    return bits64[ADDR_BITS-1:0];
  endfunction

  // Lowest and one-past-highest page of the run an init builds in the window
  function automatic longint unsigned window_lo();
    longint unsigned bound;
    bound = (win_kend > win_base) ? longint'(win_kend) : longint'(win_base);
    return (bound + longint'(OFFSET_MASK)) >> PAGE_BITS;
  endfunction

  function automatic longint unsigned window_hi();
    return longint'(win_stop) >> PAGE_BITS;
  endfunction

  function automatic addr_t window_page();
    longint unsigned lo;
    longint unsigned hi;
    lo = window_lo();
    hi = window_hi();
    if (hi <= lo) return rand_addr() & ~OFFSET_MASK;
    return addr_t'((lo + ($urandom() % (hi - lo))) << PAGE_BITS);
  endfunction

  // Mostly good frees, the rest each kind of bad address
  function automatic addr_t free_address();
    longint unsigned lo;
    lo = window_lo();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return window_page();
      4, 5: begin
        if (granted_pages.size() == 0) return window_page();
        return granted_pages[$urandom_range(0, granted_pages.size() - 1)];
      end
      6: return window_page() | addr_t'($urandom_range(1, OFFSET_MASK));
      7: begin
        if (lo == 0) return rand_addr();
        return addr_t'((lo - 1 - ($urandom() % lo)) << PAGE_BITS);
      end
      8: return addr_t'((((longint'(win_stop) + longint'(OFFSET_MASK)) >> PAGE_BITS)
                        + $urandom_range(0, 3)) << PAGE_BITS);
      default: return rand_addr();
    endcase
  endfunction

  // One request beat, after a random idle gap when idling is on
  task automatic send_request(kind_t kind, addr_t address);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_address <= address;
    do @(posedge clk); while (in_ready !== 1'b1);
    pool.accept_request(kind, address);
  endtask

  // Stop offering and wait for every predicted reply
  task automatic drain();
    in_valid <= 1'b0;
    while (pool.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(addr_t base, addr_t stop, addr_t kend);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RAM_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= REG_RAM_STOP;
    cfg_wdata <= stop;
    @(posedge clk);
    cfg_index <= REG_KERNEL_END;
    cfg_wdata <= kend;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool.write_reg(REG_RAM_BASE, base);
    pool.write_reg(REG_RAM_STOP, stop);
    pool.write_reg(REG_KERNEL_END, kend);
    win_base = base;
    win_stop = stop;
    win_kend = kend;
    window_count++;
  endtask

  // Small, medium, huge or fully random windows with a kernel end around base or random
  task automatic pick_random_window();
    longint unsigned base;
    longint unsigned stop;
    longint unsigned kend;
    longint unsigned shift;
    base = longint'($urandom_range(0, 32'h0FFF_FF00)) << PAGE_BITS;
    if ($urandom_range(0, 1)) base += $urandom_range(1, OFFSET_MASK);
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        stop = base + longint'($urandom_range(1, 48)) * 4096;
        if ($urandom_range(0, 1)) stop += $urandom_range(0, OFFSET_MASK);
      end
      3: stop = base + longint'($urandom_range(49, 4000)) * 4096;
      4: begin
        base = rand_addr();
        stop = rand_addr();
      end
      default: begin
        base = $urandom_range(0, 16'hFFFF);
        stop = ADDR_ONES - ($urandom_range(0, 1) ? 0 : $urandom_range(0, 16'hFFFF));
      end
    endcase
    case ($urandom_range(0, 3))
      0: begin
        shift = $urandom_range(0, 8 * 4096);
        kend  = (base > shift) ? base - shift : 0;
      end
      1: kend = base;
      2: kend = base + $urandom_range(1, 6 * 4096);
      default: kend = rand_addr();
    endcase
    set_window(addr_t'(base), addr_t'(stop), addr_t'(kend));
  endtask

  task automatic run_random_phase(int n_items);
    int pick;
    send_request(KIND_INIT, rand_addr());
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_request(KIND_ALLOC, rand_addr());
      else if (pick < 90) send_request(KIND_FREE, free_address());
      else if (pick < 97) send_request(KIND_INIT, rand_addr());
      else send_request(KIND_RESERVED, rand_addr());
    end
  endtask

  // Reply side: random stalls, one long hold-off on request
  initial begin : reply_sink
    int stall;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      pool.check_reply(out_page_address, out_status);
      // keep recent grants around to free them again later
      if (out_status == ST_OK && out_page_address != '0) begin
        granted_pages.push_back(out_page_address);
        if (granted_pages.size() > 64) void'(granted_pages.pop_front());
      end
    end
  end

  initial begin : stimulus
    pool = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_kind    <= KIND_ALLOC;
    in_address <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_RAM_BASE;
    cfg_wdata  <= '0;
    idle_on      = 1'b1;
    hold_len     = 0;
    window_count = 0;
    win_base     = '0;
    win_stop     = '0;
    win_kend     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window is empty: nothing to hand out, every free is bad
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, '0);
    send_request(KIND_INIT, ADDR_ONES);
    send_request(KIND_ALLOC, ADDR_ONES);
    send_request(KIND_RESERVED, ADDR_ONES);
    drain();

    // Unaligned kernel end and stop: pages 3..7, then the free checks
    set_window(40'h3000, 40'h8800, 40'h2001);
    send_request(KIND_INIT, '0);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, 40'h7000);
    send_request(KIND_FREE, 40'h2000);
    send_request(KIND_FREE, 40'h3001);
    send_request(KIND_FREE, 40'h8000);
    send_request(KIND_FREE, 40'h9000);
    repeat (7) send_request(KIND_ALLOC, '0);
    send_request(KIND_RESERVED, '0);
    drain();

    // Whole address space
    set_window('0, ADDR_ONES, '0);
    send_request(KIND_INIT, '0);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, ADDR_ONES & ~OFFSET_MASK);
    send_request(KIND_FREE, ADDR_ONES);
    send_request(KIND_ALLOC, '0);
    drain();

    // Everything at the top: empty window
    set_window(ADDR_ONES, ADDR_ONES, ADDR_ONES);
    send_request(KIND_INIT, '0);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, ADDR_ONES & ~OFFSET_MASK);

    // Random phases; every third runs without idling, one holds the reply side off
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      pick_random_window();
      idle_on = (phase % 3 != 1);
      if (phase == 4) hold_len = HOLD_CYCLES;
      run_random_phase(PHASE_ITEMS);
    end

    // Push a burst of frees back to back, then pop them and more
    drain();
    idle_on = 1'b0;
    set_window(40'h10000, 40'h90000, 40'h4000);
    send_request(KIND_INIT, '0);
    repeat (BURST_ITEMS) send_request(KIND_FREE, window_page());
    idle_on = 1'b1;
    repeat (24) send_request(KIND_ALLOC, rand_addr());
    repeat (8) send_request(KIND_FREE, free_address());
    send_request(KIND_ALLOC, rand_addr());
    drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests over %0d windows: %0d pages granted, %0d out of memory,",
             pool.requests, window_count, pool.granted, pool.out_of_memory);
    $display("%0d bad addresses, %0d frees on a full stack, %0d list rebuilds, %0d mismatches.",
             pool.rejected, pool.overflowed, pool.rebuilds, pool.mismatches);
    if (pool.mismatches == 0) begin
      $display("** free_page_stack_allocator: PASSED **");
    end else begin
      $display("** free_page_stack_allocator: FAILED **");
    end
    $finish;
  end

endmodule
